@@ hw/rtl/slbc_pkg.sv @@
// Package for the status LED blink controller: field widths, display modes,
// configuration register indexes and their reset values.
// No dependencies.
package slbc_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned CFG_IDX_W = 3;

    // Display mode as seen on the result beat.
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ON   = 2'd1,
        MODE_SLOW = 2'd2,
        MODE_FAST = 2'd3
    } t_mode;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_TOGGLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_POLARITY   = 3'd4;

    // Configuration reset values.
    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST   = 16'd2000;
    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST   = 16'd120;
    localparam logic [PERIOD_W-1:0] BURST_PERIOD_RST  = 16'd150;
    localparam logic [COUNT_W-1:0]  BURST_TOGGLES_RST = 4'd4;
    localparam logic                ON_POLARITY_RST   = 1'b1;

    localparam logic [PERIOD_W-1:0] ELAPSED_MAX = '1;

endpackage

@@ hw/rtl/status_led_blink_controller_unit.sv @@
// Top level of the status LED blink controller: one tick beat in, one LED
// result beat out. Uses slbc_pkg for modes, register indexes and widths.
//
//  Channel   Direction  Handshake                     Payload
//  in        sink       i_in_valid / o_in_ready       pairing, overheat, error, burst request
//  out       source     o_out_valid / i_out_ready     led_pin, active_mode, burst_busy
//  cfg       sink       i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// Each tick is resolved in the cycle it is accepted; its result appears in the
// result register on the next cycle, and one tick can be taken every cycle unless
// the output stalls. The state update and the result register share one
// short compare-and-increment path. The input side stalls only while a result
// is held and the sink is not ready. Reset is synchronous and returns all
// configuration registers to their defaults and the LED state to dark, mode off.
module status_led_blink_controller_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Tick channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_pairing_flag,
    input  logic                              i_overheat_flag,
    input  logic                              i_error_flag,
    input  logic                              i_burst_request,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_led_pin,
    output logic [1:0]                        o_active_mode,
    output logic                              o_burst_busy,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [slbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [slbc_pkg::PERIOD_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [slbc_pkg::PERIOD_W-1:0] r_slow_period;
    logic [slbc_pkg::PERIOD_W-1:0] r_fast_period;
    logic [slbc_pkg::PERIOD_W-1:0] r_burst_period;
    logic [slbc_pkg::COUNT_W-1:0]  r_burst_toggles;
    logic                          r_on_polarity;

    // Controller state.
    logic [slbc_pkg::PERIOD_W-1:0] r_elapsed;
    slbc_pkg::t_mode               r_mode;
    logic                          r_lamp_on;
    logic [slbc_pkg::COUNT_W-1:0]  r_burst_left;

    logic [slbc_pkg::PERIOD_W-1:0] n_elapsed;
    slbc_pkg::t_mode               n_mode;
    logic                          n_lamp_on;
    logic [slbc_pkg::COUNT_W-1:0]  n_burst_left;

    // Result register.
    logic                          r_out_valid;
    logic                          r_out_led;
    slbc_pkg::t_mode               r_out_mode;
    logic                          r_out_busy;

    logic                          in_fire;
    slbc_pkg::t_mode               req_mode;
    logic [slbc_pkg::PERIOD_W-1:0] blink_period;

    // A new beat is taken whenever the result register is empty or draining.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_period   <= slbc_pkg::SLOW_PERIOD_RST;
            r_fast_period   <= slbc_pkg::FAST_PERIOD_RST;
            r_burst_period  <= slbc_pkg::BURST_PERIOD_RST;
            r_burst_toggles <= slbc_pkg::BURST_TOGGLES_RST;
            r_on_polarity   <= slbc_pkg::ON_POLARITY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slbc_pkg::CFG_SLOW_PERIOD:   r_slow_period   <= i_cfg_data;
                slbc_pkg::CFG_FAST_PERIOD:   r_fast_period   <= i_cfg_data;
                slbc_pkg::CFG_BURST_PERIOD:  r_burst_period  <= i_cfg_data;
                slbc_pkg::CFG_BURST_TOGGLES: r_burst_toggles <= i_cfg_data[slbc_pkg::COUNT_W-1:0];
                slbc_pkg::CFG_ON_POLARITY:   r_on_polarity   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Priority resolution of the status flags.
    always_comb begin
        if (i_pairing_flag) begin
            req_mode = slbc_pkg::MODE_ON;
        end else if (i_overheat_flag) begin
            req_mode = slbc_pkg::MODE_FAST;
        end else if (i_error_flag) begin
            req_mode = slbc_pkg::MODE_SLOW;
        end else begin
            req_mode = slbc_pkg::MODE_OFF;
        end
    end

    assign blink_period = (req_mode == slbc_pkg::MODE_SLOW) ? r_slow_period : r_fast_period;

    // One tick of the controller: saturating count, burst, then mode logic.
    always_comb begin
        n_mode       = r_mode;
        n_lamp_on    = r_lamp_on;
        n_burst_left = r_burst_left;
        n_elapsed    = (r_elapsed == slbc_pkg::ELAPSED_MAX) ? r_elapsed
                                                             : r_elapsed + 1'b1;

        // A request restarts the burst with the first toggle due at once.
        if (i_burst_request) begin
            n_lamp_on    = 1'b0;
            n_elapsed    = r_burst_period;
            n_burst_left = r_burst_toggles;
        end

        if (n_burst_left != '0) begin
            if (n_elapsed >= r_burst_period) begin
                n_lamp_on    = !n_lamp_on;
                n_elapsed    = '0;
                n_burst_left = n_burst_left - 1'b1;
            end
            // The end of a burst leaves the LED dark and forgets the mode.
            if (n_burst_left == '0) begin
                n_lamp_on = 1'b0;
                n_mode    = slbc_pkg::MODE_OFF;
                n_elapsed = '0;
            end
        end else begin
            if (req_mode != r_mode) begin
                n_mode    = req_mode;
                n_elapsed = '0;
                n_lamp_on = (req_mode == slbc_pkg::MODE_SLOW) ||
                            (req_mode == slbc_pkg::MODE_FAST);
            end
            case (req_mode)
                slbc_pkg::MODE_ON: begin
                    n_lamp_on = 1'b1;
                end
                slbc_pkg::MODE_SLOW, slbc_pkg::MODE_FAST: begin
                    if (n_elapsed >= blink_period) begin
                        n_lamp_on = !n_lamp_on;
                        n_elapsed = '0;
                    end
                end
                default: begin
                    n_lamp_on = 1'b0;
                end
            endcase
        end
    end

    // State update on every accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed    <= '0;
            r_mode       <= slbc_pkg::MODE_OFF;
            r_lamp_on    <= 1'b0;
            r_burst_left <= '0;
        end else if (in_fire) begin
            r_elapsed    <= n_elapsed;
            r_mode       <= n_mode;
            r_lamp_on    <= n_lamp_on;
            r_burst_left <= n_burst_left;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_led  <= n_lamp_on ? r_on_polarity : !r_on_polarity;
            r_out_mode <= n_mode;
            r_out_busy <= (n_burst_left != '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_pin     = r_out_led;
    assign o_active_mode = r_out_mode;
    assign o_burst_busy  = r_out_busy;

    // Steady-on mode outside a burst always keeps the LED lit.
    a_on_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_burst_left == '0 && r_mode == slbc_pkg::MODE_ON) |-> r_lamp_on)
        else $error("steady-on mode with LED dark");

    // Off mode outside a burst always keeps the LED dark.
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_burst_left == '0 && r_mode == slbc_pkg::MODE_OFF) |-> !r_lamp_on)
        else $error("off mode with LED lit");

    // A running burst keeps the mode, and clears it to off when it ends.
    a_burst_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_burst_left != '0 && !i_burst_request) |=>
        ((r_burst_left == '0) ? (r_mode == slbc_pkg::MODE_OFF)
                              : (r_mode == $past(r_mode))))
        else $error("mode changed during a burst");

    // A request for a burst longer than one toggle reports busy on its result.
    a_burst_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_burst_request && r_burst_toggles > 4'd1) |=>
        (r_out_busy && r_out_valid))
        else $error("burst request not reported busy");

endmodule
